>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same, on the usual clock and reset names of this block
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop)

`endif

>>> rtl/iwd_pkg.sv
// ----------------------------------------------------------------------------
// iwd_pkg
// types, decode table and constants of the instruction word decoder
// ----------------------------------------------------------------------------
`default_nettype none

package iwd_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned RAW_W     = 32;
  localparam int unsigned SIZE_W    = 3;
  localparam int unsigned ROW_COUNT = 109;
  localparam int unsigned ROW_IDX_W = 7;

  localparam logic [SIZE_W-1:0] SIZE_SHORT = 3'd2;
  localparam logic [SIZE_W-1:0] SIZE_LONG  = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic [WORD_W-1:0] mask;
    logic              four_byte;
  } row_t;

  typedef struct packed {
    logic                 found;
    logic [ROW_IDX_W-1:0] row_index;
    logic [SIZE_W-1:0]    byte_size;
    logic [RAW_W-1:0]     raw_instruction;
  } result_t;

  // ordered table, first match wins; aliases and shadowed rows keep their place
  localparam row_t ROW_TABLE [ROW_COUNT] = '{
    '{16'h0C00, 16'hFC00, 1'b0}, '{16'h1C00, 16'hFC00, 1'b0},
    '{16'h9600, 16'hFF00, 1'b0}, '{16'h1800, 16'hFC00, 1'b0},
    '{16'h5000, 16'hF000, 1'b0}, '{16'h0800, 16'hFC00, 1'b0},
    '{16'h4000, 16'hF000, 1'b0}, '{16'h0200, 16'hFF00, 1'b0},
    '{16'h0300, 16'hFF88, 1'b0}, '{16'h2000, 16'hFC00, 1'b0},
    '{16'h7000, 16'hF000, 1'b0}, '{16'h2800, 16'hFC00, 1'b0},
    '{16'h6000, 16'hF000, 1'b0}, '{16'h2400, 16'hFC00, 1'b0},
    '{16'h9400, 16'hFE0F, 1'b0}, '{16'h9401, 16'hFE0F, 1'b0},
    '{16'h6000, 16'hF000, 1'b0}, '{16'h7000, 16'hF000, 1'b0},
    '{16'h9403, 16'hFE0F, 1'b0}, '{16'h940A, 16'hFE0F, 1'b0},
    '{16'h2000, 16'hFC00, 1'b0}, '{16'h2400, 16'hFC00, 1'b0},
    '{16'hEF0F, 16'hFF0F, 1'b0}, '{16'hE000, 16'hF000, 1'b0},
    '{16'h900C, 16'hFE0F, 1'b0}, '{16'h900D, 16'hFE0F, 1'b0},
    '{16'h900E, 16'hFE0F, 1'b0}, '{16'h8008, 16'hFE0F, 1'b0},
    '{16'h9009, 16'hFE0F, 1'b0}, '{16'h900A, 16'hFE0F, 1'b0},
    '{16'h8008, 16'hD208, 1'b0}, '{16'h8000, 16'hFE0F, 1'b0},
    '{16'h9001, 16'hFE0F, 1'b0}, '{16'h9002, 16'hFE0F, 1'b0},
    '{16'h8000, 16'hD208, 1'b0}, '{16'h920C, 16'hFE0F, 1'b0},
    '{16'h920D, 16'hFE0F, 1'b0}, '{16'h920E, 16'hFE0F, 1'b0},
    '{16'h8208, 16'hFE0F, 1'b0}, '{16'h9209, 16'hFE0F, 1'b0},
    '{16'h920A, 16'hFE0F, 1'b0}, '{16'h8208, 16'hD208, 1'b0},
    '{16'h8200, 16'hFE0F, 1'b0}, '{16'h9201, 16'hFE0F, 1'b0},
    '{16'h9202, 16'hFE0F, 1'b0}, '{16'h8200, 16'hD208, 1'b0},
    '{16'h95C8, 16'hFFFF, 1'b0}, '{16'h9004, 16'hFE0F, 1'b0},
    '{16'h9005, 16'hFE0F, 1'b0}, '{16'h9700, 16'hFF00, 1'b0},
    '{16'hA800, 16'hF800, 1'b0}, '{16'h2C00, 16'hFC00, 1'b0},
    '{16'h0100, 16'hFF00, 1'b0},
    '{16'hC000, 16'hF000, 1'b0}, '{16'hD000, 16'hF000, 1'b0},
    '{16'h9508, 16'hFFFF, 1'b0}, '{16'h9518, 16'hFFFF, 1'b0},
    '{16'h1000, 16'hFC00, 1'b0}, '{16'h1400, 16'hFC00, 1'b0},
    '{16'h0400, 16'hFC00, 1'b0}, '{16'h3000, 16'hF000, 1'b0},
    '{16'hFC00, 16'hFE08, 1'b0}, '{16'hFE00, 16'hFE08, 1'b0},
    '{16'h9900, 16'hFF00, 1'b0}, '{16'h9B00, 16'hFF00, 1'b0},
    '{16'hF001, 16'hFC07, 1'b0}, '{16'hF401, 16'hFC07, 1'b0},
    '{16'hF000, 16'hFC07, 1'b0}, '{16'hF400, 16'hFC07, 1'b0},
    '{16'hF400, 16'hFC07, 1'b0}, '{16'hF000, 16'hFC07, 1'b0},
    '{16'hF002, 16'hFC07, 1'b0}, '{16'hF402, 16'hFC07, 1'b0},
    '{16'hF404, 16'hFC07, 1'b0}, '{16'hF004, 16'hFC07, 1'b0},
    '{16'hF005, 16'hFC07, 1'b0}, '{16'hF405, 16'hFC07, 1'b0},
    '{16'hF006, 16'hFC07, 1'b0}, '{16'hF406, 16'hFC07, 1'b0},
    '{16'hF003, 16'hFC07, 1'b0}, '{16'hF403, 16'hFC07, 1'b0},
    '{16'hF007, 16'hFC07, 1'b0}, '{16'hF407, 16'hFC07, 1'b0},
    '{16'hF000, 16'hFC00, 1'b0}, '{16'hF400, 16'hFC00, 1'b0},
    '{16'h9A00, 16'hFF00, 1'b0}, '{16'h9800, 16'hFF00, 1'b0},
    '{16'h0C00, 16'hFC00, 1'b0}, '{16'h9406, 16'hFE0F, 1'b0},
    '{16'h1C00, 16'hFC00, 1'b0}, '{16'h9407, 16'hFE0F, 1'b0},
    '{16'h9405, 16'hFE0F, 1'b0}, '{16'h9402, 16'hFE0F, 1'b0},
    '{16'h9478, 16'hFFFF, 1'b0}, '{16'h9408, 16'hFF8F, 1'b0},
    '{16'h94F8, 16'hFFFF, 1'b0}, '{16'h9488, 16'hFF8F, 1'b0},
    '{16'h0000, 16'hFFFF, 1'b0}, '{16'h9588, 16'hFFFF, 1'b0},
    '{16'h95A8, 16'hFFFF, 1'b0}, '{16'h9598, 16'hFFFF, 1'b0},
    '{16'h900F, 16'hFE0F, 1'b0}, '{16'h920F, 16'hFE0F, 1'b0},
    '{16'hB000, 16'hF800, 1'b0}, '{16'hB800, 16'hF800, 1'b0},
    '{16'h940E, 16'hFE0E, 1'b1}, '{16'h940C, 16'hFE0E, 1'b1},
    '{16'h9000, 16'hFE0F, 1'b1}, '{16'h9200, 16'hFE0F, 1'b1}
  };

endpackage

`default_nettype wire

>>> rtl/iwd_match.sv
// ----------------------------------------------------------------------------
// iwd_match
// masked compare of the first word against every table row, then a
// priority pick of the lowest matching row and assembly of the result
// ----------------------------------------------------------------------------
`default_nettype none

module iwd_match (
  input  wire logic [iwd_pkg::WORD_W-1:0] first_word_i,
  input  wire logic [iwd_pkg::WORD_W-1:0] second_word_i,
  output iwd_pkg::result_t                result_o
);

  logic [iwd_pkg::ROW_COUNT-1:0] hit;

  // independent compares, one per row
  always_comb begin
    for (int i = 0; i < iwd_pkg::ROW_COUNT; i++) begin
      hit[i] = (first_word_i & iwd_pkg::ROW_TABLE[i].mask) == iwd_pkg::ROW_TABLE[i].pattern;
    end
  end

  // walk from the last row down so the lowest hit is left standing
  always_comb begin
    result_o.found           = 1'b0;
    result_o.row_index       = '0;
    result_o.byte_size       = iwd_pkg::SIZE_SHORT;
    result_o.raw_instruction = '0;
    for (int i = iwd_pkg::ROW_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        result_o.found     = 1'b1;
        result_o.row_index = iwd_pkg::ROW_IDX_W'(i);
        if (iwd_pkg::ROW_TABLE[i].four_byte) begin
          result_o.byte_size       = iwd_pkg::SIZE_LONG;
          result_o.raw_instruction = {second_word_i, first_word_i};
        end else begin
          result_o.byte_size       = iwd_pkg::SIZE_SHORT;
          result_o.raw_instruction = {{(iwd_pkg::RAW_W - iwd_pkg::WORD_W){1'b0}}, first_word_i};
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mcu_instruction_word_decoder_unit.sv
// an accepted input transaction moves through the input register, then the result register
// throughput: one transaction per cycle while the master side is ready, set by the
//   single table match stage between the input register and the result register
// a stalled master side holds the result register; the input register still takes one more
// reset: asynchronous, active low; clears both valid flags, payload registers are not reset
// ----------------------------------------------------------------------------
// mcu_instruction_word_decoder_unit
// two-stage stream decoder matching an instruction word against a fixed table
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mcu_instruction_word_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] first_word, [31:16] second_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [6:0] row_index, [9:7] byte_size,
                                           // [41:10] raw_instruction, [47:42] zero
  output logic             m_axis_tuser    // [0] found
);

  logic                          in_valid_q, in_valid_d;
  logic [iwd_pkg::WORD_W-1:0]    first_q, second_q;
  logic                          out_valid_q, out_valid_d;
  iwd_pkg::result_t              res_q, res_d;
  logic                          s_accept, advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  iwd_match u_match (
    .first_word_i  (first_q),
    .second_word_i (second_q),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      first_q  <= s_axis_tdata[15:0];
      second_q <= s_axis_tdata[31:16];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.found;
  assign m_axis_tdata  = {6'b0, res_q.raw_instruction, res_q.byte_size, res_q.row_index};

  // an accepted transaction is always held in the input register next cycle
  `ASSERT_DEF(a_accept_loads, s_accept |=> in_valid_q)
  // a pending word moving on always shows up as a result
  `ASSERT_DEF(a_advance_shows, advance |=> m_axis_tvalid)
  // unknown words report index 0, short size and zero raw word
  `ASSERT_DEF(a_unknown_clean, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 48'h0000_0000_0100))
  // short forms never carry a second word
  `ASSERT_DEF(a_short_upper_zero, (m_axis_tvalid && m_axis_tdata[9:7] == iwd_pkg::SIZE_SHORT) |-> (m_axis_tdata[41:26] == 16'h0000))

endmodule

`default_nettype wire
